[rtl/core/rotate_in_place_velocity_profiler_defines.svh]
// Assertion macros shared by the profiler RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ROTATE_IN_PLACE_VELOCITY_PROFILER_DEFINES_SVH
`define ROTATE_IN_PLACE_VELOCITY_PROFILER_DEFINES_SVH

// Same-cycle implication.
`define RIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rip_pkg.sv]
// Types, codes and constants of the rotate-in-place velocity profiler.
// No dependencies; the design modules and the testbench import it.
`timescale 1ns / 1ps
package rip_pkg;

  typedef enum logic [2:0] {
    S_IDLE, S_YAW, S_ODOM, S_TICK, S_START, S_CALC, S_SPEED, S_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {PH_WAIT, PH_INIT, PH_ROT, PH_DONE} phase_t;

  typedef enum logic [2:0] {C_IDLE, C_MUL, C_PRE, C_ITER, C_OUT} cor_state_t;

  localparam logic [1:0] ST_DRIVE   = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic CMD_ODOM = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_MAXRATE = 3'd1;
  localparam logic [2:0] REG_ACCEL   = 3'd2;
  localparam logic [2:0] REG_TOL     = 3'd3;
  localparam logic [2:0] REG_MINRATE = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  localparam logic signed [22:0] TARGET_RST  = 23'sd102943;
  localparam logic [19:0]        MAXRATE_RST = 20'd65536;
  localparam logic [19:0]        ACCEL_RST   = 20'd32768;
  localparam logic [15:0]        TOL_RST     = 16'd1311;
  localparam logic [19:0]        MINRATE_RST = 20'd9830;
  localparam logic [21:0]        TIMEOUT_RST = 22'd500000;

  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] TWO_PI_Q16  = 20'sd411775;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [31:0]        TICK_MAX_US = 32'd1000000;

  // Reciprocal of 15625 scaled by 2^47 and rounded up. After a 6-bit right shift
  // it divides exactly by one million for dividends below 2^40.
  localparam logic [33:0]        US_RECIP    = 34'd9007199255;

  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] a;
    unique case (i)
      5'd0:  a = 28'sd13176795;
      5'd1:  a = 28'sd7778716;
      5'd2:  a = 28'sd4110060;
      5'd3:  a = 28'sd2086331;
      5'd4:  a = 28'sd1047214;
      5'd5:  a = 28'sd524117;
      5'd6:  a = 28'sd262123;
      5'd7:  a = 28'sd131069;
      5'd8:  a = 28'sd65536;
      5'd9:  a = 28'sd32768;
      5'd10: a = 28'sd16384;
      5'd11: a = 28'sd8192;
      5'd12: a = 28'sd4096;
      5'd13: a = 28'sd2048;
      5'd14: a = 28'sd1024;
      5'd15: a = 28'sd512;
      5'd16: a = 28'sd256;
      5'd17: a = 28'sd128;
      5'd18: a = 28'sd64;
      5'd19: a = 28'sd32;
      5'd20: a = 28'sd16;
      5'd21: a = 28'sd8;
      5'd22: a = 28'sd4;
      5'd23: a = 28'sd2;
      default: a = 28'sd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/rip_in_if.sv]
// Input channel of the profiler: odometry and tick beats.
// No dependencies.
`timescale 1ns / 1ps
interface rip_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [31:0]        now_us;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source(output valid, cmd, now_us, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, cmd, now_us, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

[rtl/core/rip_out_if.sv]
// Output channel of the profiler: rate command beats.
// No dependencies.
`timescale 1ns / 1ps
interface rip_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] angular_rate;
  logic [1:0]         status;
  modport source(output valid, angular_rate, status, input ready);
  modport sink(input valid, angular_rate, status, output ready);
endinterface

[rtl/core/rip_cordic.sv]
// Iterative vectoring CORDIC that turns a quaternion into a yaw angle.
// One shared multiplier forms the products, one add/shift stage iterates. Uses rip_pkg.
`timescale 1ns / 1ps
module rip_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] qx,
  input  logic signed [15:0] qy,
  input  logic signed [15:0] qz,
  input  logic signed [15:0] qw,
  output logic               busy,
  output logic signed [18:0] yaw
);
  import rip_pkg::*;

  localparam int CW = $clog2(STEPS);

  cor_state_t state, state_next;
  logic [1:0] k;
  logic [CW-1:0] it;
  logic signed [15:0] ax, ay, az, aw, ma, mb;
  logic signed [31:0] prod;
  logic signed [32:0] acc_x, acc_y;
  logic signed [35:0] x, y, x0, y0, dx, dy;
  logic signed [27:0] z, rnd;
  logic degen;

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: if (start) state_next = C_MUL;
      C_MUL:  if (k == 2'd3) state_next = C_PRE;
      C_PRE:  state_next = C_ITER;
      C_ITER: if (it == CW'(STEPS - 1)) state_next = C_OUT;
      C_OUT:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != C_IDLE);
  end

  always_comb begin
    case (k)
      2'd0:    begin ma = aw; mb = az; end
      2'd1:    begin ma = ax; mb = ay; end
      2'd2:    begin ma = ay; mb = ay; end
      default: begin ma = az; mb = az; end
    endcase
    prod = ma * mb;
    x0   = 36'sh040000000 - {{2{acc_x[32]}}, acc_x, 1'b0};
    y0   = {{2{acc_y[32]}}, acc_y, 1'b0};
    dx   = y >>> it;
    dy   = x >>> it;
    rnd  = z + 28'sd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          ax <= qx;
          ay <= qy;
          az <= qz;
          aw <= qw;
          k <= 2'd0;
          acc_x <= '0;
          acc_y <= '0;
        end
      end
      C_MUL: begin
        if (k[1]) begin
          acc_x <= acc_x + {prod[31], prod};
        end else begin
          acc_y <= acc_y + {prod[31], prod};
        end
        k <= k + 2'd1;
      end
      C_PRE: begin
        degen <= (x0 == '0) && (y0 == '0);
        it <= '0;
        if (x0 < 0) begin
          if (y0 >= 0) begin
            x <= y0;
            y <= -x0;
            z <= HALF_PI_Q24;
          end else begin
            x <= -y0;
            y <= x0;
            z <= -HALF_PI_Q24;
          end
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end
      C_ITER: begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_q24(5'(it));
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_q24(5'(it));
        end
        it <= it + 1'b1;
      end
      C_OUT: begin
        yaw <= degen ? '0 : rnd[26:8];
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/rip_isqrt.sv]
// Bit-pair restoring integer square root, one step per cycle.
// Uses rip_pkg.
`timescale 1ns / 1ps
module rip_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] val,
  output logic        busy,
  output logic [27:0] root
);
  import rip_pkg::*;

  logic [55:0] v, r, b, rb;

  assign rb   = r + b;
  assign root = r[27:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (b == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= val;
      r <= '0;
      b <= 56'd1 << 54;
    end else if (busy && (b != '0)) begin
      if (v >= rb) begin
        v <= v - rb;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

[rtl/core/rip_cdiv.sv]
// Division by one million by reciprocal multiplication, taking the upper half of the dividend before the lower.
// The quotient fits 20 bits for the operands used here. Uses rip_pkg.
`timescale 1ns / 1ps
module rip_cdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] num,
  output logic        busy,
  output logic [19:0] quo
);
  import rip_pkg::*;

  logic [33:0] nsh;
  logic        step;
  logic [16:0] half;
  logic [50:0] part;
  logic [66:0] acc;

  assign half = step ? nsh[16:0] : nsh[33:17];
  assign part = {34'd0, half} * {17'd0, US_RECIP};
  assign quo  = acc[66:47];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num[39:6];
      step <= 1'b0;
      acc  <= '0;
    end else if (busy) begin
      if (step) begin
        acc <= acc + {16'd0, part};
      end else begin
        acc <= 67'({part, 17'd0});
      end
      step <= 1'b1;
    end
  end

endmodule

[rtl/core/rotate_in_place_velocity_profiler.sv]
// Odometry beats run the CORDIC products and iterations, then update the heading and the distance travelled.
// Skipped ticks return straight to idle and stop ticks go to the output; a drive tick runs the 28-step
// square root, with the divide done beside it. A result still waiting on the output stalls them.
// One beat is worked on at a time; the input is ready only between beats.
// Synchronous reset restores the register defaults, the waiting phase and zero timestamps.
// Depends on rip_pkg, rip_in_if, rip_out_if, rip_cordic, rip_isqrt, rip_cdiv and the defines header.
`timescale 1ns / 1ps
`include "rotate_in_place_velocity_profiler_defines.svh"
module rotate_in_place_velocity_profiler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rip_in_if.sink      in_ch,
  rip_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rip_pkg::*;

  seq_state_t state, state_next;
  phase_t phase;

  logic signed [22:0] target;
  logic [19:0] max_rate, max_accel, min_rate;
  logic [15:0] tolerance;
  logic [21:0] odom_timeout;

  logic signed [18:0] last_yaw;
  logic signed [31:0] travelled;
  logic [19:0] rate_cmd;
  logic [31:0] last_tick, last_odom;

  logic cmd_r;
  logic [31:0] now_r;
  logic signed [20:0] res_rate;
  logic [1:0] res_status;
  logic [54:0] sq_arg;
  logic [39:0] dv_arg;

  logic out_valid, emit_load, accept, cor_start, unit_start;
  logic cor_busy, sq_busy, dv_busy;
  logic signed [18:0] yaw;
  logic [27:0] kin;
  logic [19:0] quo;

  logic [31:0] dt, age;
  logic tick_bad, stale, too_small, reached, pos, tk_emit, tk_run;
  logic [23:0] tmag;
  logic signed [31:0] tr_eff;
  logic signed [33:0] t34, tol34, tr34, diff;
  logic [33:0] rem;
  logic [54:0] sq_prod;
  logic [39:0] dv_prod;
  logic signed [19:0] d, dw;
  logic signed [32:0] tsum;
  logic [20:0] acc;
  logic [27:0] w1, w2, w3;

  rip_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start),
    .qx(in_ch.quat_x), .qy(in_ch.quat_y), .qz(in_ch.quat_z), .qw(in_ch.quat_w),
    .busy(cor_busy), .yaw(yaw)
  );

  rip_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(unit_start), .val({1'b0, sq_arg}),
    .busy(sq_busy), .root(kin)
  );

  rip_cdiv u_cdiv (
    .clk(clk), .rst(rst), .start(unit_start), .num(dv_arg),
    .busy(dv_busy), .quo(quo)
  );

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target       <= TARGET_RST;
      max_rate     <= MAXRATE_RST;
      max_accel    <= ACCEL_RST;
      tolerance    <= TOL_RST;
      min_rate     <= MINRATE_RST;
      odom_timeout <= TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_TARGET:  target       <= pwdata[22:0];
        REG_MAXRATE: max_rate     <= pwdata[19:0];
        REG_ACCEL:   max_accel    <= pwdata[19:0];
        REG_TOL:     tolerance    <= pwdata[15:0];
        REG_MINRATE: min_rate     <= pwdata[19:0];
        REG_TIMEOUT: odom_timeout <= pwdata[21:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET:  prdata = {{9{target[22]}}, target};
      REG_MAXRATE: prdata = {12'd0, max_rate};
      REG_ACCEL:   prdata = {12'd0, max_accel};
      REG_TOL:     prdata = {16'd0, tolerance};
      REG_MINRATE: prdata = {12'd0, min_rate};
      REG_TIMEOUT: prdata = {10'd0, odom_timeout};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    dt        = now_r - last_tick;
    age       = now_r - last_odom;
    tick_bad  = (dt == '0) || (dt > TICK_MAX_US);
    stale     = age > {10'd0, odom_timeout};
    tmag      = target[22] ? -{target[22], target} : {1'b0, target};
    too_small = tmag < {8'd0, tolerance};
    tr_eff    = (phase == PH_INIT) ? '0 : travelled;
    t34       = {{11{target[22]}}, target};
    tol34     = {18'd0, tolerance};
    tr34      = {{2{tr_eff[31]}}, tr_eff};
    pos       = !target[22];
    reached   = pos ? (tr34 >= t34 - tol34) : (tr34 <= t34 + tol34);
    diff      = t34 - tr34;
    rem       = diff[33] ? 34'(-diff) : 34'(diff);
    sq_prod   = {34'd0, max_accel, 1'b0} * {21'd0, rem};
    dv_prod   = {20'd0, max_accel} * {20'd0, dt[19:0]};
    tk_emit   = (phase == PH_DONE) ||
                ((phase != PH_WAIT) && !tick_bad && stale);
    tk_run    = ((phase == PH_INIT) || (phase == PH_ROT)) && !tick_bad && !stale &&
                !((phase == PH_INIT) && too_small) && !reached;
  end

  always_comb begin
    d  = {yaw[18], yaw} - {last_yaw[18], last_yaw};
    dw = d;
    if (d > PI_Q16) begin
      dw = d - TWO_PI_Q16;
    end else if (d < -PI_Q16) begin
      dw = d + TWO_PI_Q16;
    end
    tsum = {travelled[31], travelled} + {{13{dw[19]}}, dw};
  end

  always_comb begin
    acc = {1'b0, rate_cmd} + {1'b0, quo};
    w1  = {8'd0, max_rate};
    if ({7'd0, acc} < w1) begin
      w1 = {7'd0, acc};
    end
    if (kin < w1) begin
      w1 = kin;
    end
    w2 = (w1 < {8'd0, min_rate}) ? {8'd0, min_rate} : w1;
    w3 = (w2 > {8'd0, max_rate}) ? {8'd0, max_rate} : w2;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = (in_ch.cmd == CMD_TICK) ? S_TICK : S_YAW;
      S_YAW:   if (!cor_busy) state_next = S_ODOM;
      S_ODOM:  state_next = S_IDLE;
      S_TICK:  state_next = tk_emit ? S_EMIT : (tk_run ? S_START : S_IDLE);
      S_START: state_next = S_CALC;
      S_CALC:  if (!sq_busy && !dv_busy) state_next = S_SPEED;
      S_SPEED: state_next = S_EMIT;
      S_EMIT:  if (emit_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == S_IDLE);
    accept      = in_ch.valid && (state == S_IDLE);
    cor_start   = accept && (in_ch.cmd == CMD_ODOM);
    unit_start  = (state == S_START);
    emit_load   = (state == S_EMIT) && (!out_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      travelled <= '0;
      rate_cmd  <= '0;
      last_tick <= '0;
      last_odom <= '0;
    end else begin
      case (state)
        S_ODOM: begin
          last_odom <= now_r;
          last_yaw  <= yaw;
          if (phase == PH_WAIT) begin
            phase <= PH_INIT;
          end else if (phase == PH_ROT) begin
            if (tsum > 33'sh07FFFFFFF) begin
              travelled <= 32'sh7FFFFFFF;
            end else if (tsum < -33'sh080000000) begin
              travelled <= 32'sh80000000;
            end else begin
              travelled <= tsum[31:0];
            end
          end
        end
        S_TICK: begin
          if (phase == PH_DONE) begin
            rate_cmd <= '0;
          end else if (phase != PH_WAIT) begin
            last_tick <= now_r;
            if (!tick_bad) begin
              if (stale) begin
                rate_cmd <= '0;
              end else if ((phase == PH_INIT) && too_small) begin
                phase <= PH_DONE;
              end else begin
                if (phase == PH_INIT) begin
                  travelled <= '0;
                  phase <= PH_ROT;
                end
                if (reached) begin
                  phase <= PH_DONE;
                end
              end
            end
          end
        end
        S_SPEED: begin
          rate_cmd <= w3[19:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      now_r <= in_ch.now_us;
    end
    if (state == S_TICK) begin
      sq_arg     <= sq_prod;
      dv_arg     <= dv_prod;
      res_rate   <= '0;
      res_status <= (phase == PH_DONE) ? ST_DONE : ST_TIMEOUT;
    end
    if (state == S_SPEED) begin
      res_rate   <= pos ? {1'b0, w3[19:0]} : -{1'b0, w3[19:0]};
      res_status <= ST_DRIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_ch.angular_rate <= res_rate;
      out_ch.status       <= res_status;
    end
  end

  assign out_ch.valid = out_valid;

  `RIP_ASSERT_IMP(a_stop_is_zero, out_ch.valid && (out_ch.status != ST_DRIVE), out_ch.angular_rate == '0, "stop beat with nonzero rate")
  `RIP_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input ready right after a beat")
  `RIP_ASSERT_IMP(a_status_code, out_ch.valid, (out_ch.status == ST_DRIVE) || (out_ch.status == ST_DONE) || (out_ch.status == ST_TIMEOUT), "undefined status code")
  `RIP_ASSERT_IMP(a_tick_no_cordic, (state == S_TICK) || (state == S_CALC), !cor_busy && (cmd_r == CMD_TICK), "CORDIC active during tick")

endmodule

[sim/testbench.sv]
// Self-checking testbench for the rotate-in-place velocity profiler.
// Drives odometry and tick beats with random idling, predicts every rate command
// and compares it; depends on rip_pkg, rip_in_if, rip_out_if and the profiler RTL.
`timescale 1ns / 1ps
module testbench;
  import rip_pkg::*;

  typedef struct {
    logic        cmd;
    logic [31:0] now_us;
    logic signed [15:0] qx, qy, qz, qw;
  } beat_t;

  typedef struct {
    logic signed [20:0] rate;
    logic [1:0]         status;
  } rate_cmd_t;

  class rate_scoreboard;
    rate_cmd_t pending[$];
    int errors;
    longint target;
    longint unsigned max_rate, max_accel, tol, min_rate, timeout;
    phase_t ph;
    longint last_yaw, travelled;
    longint unsigned rate_now;
    logic [31:0] last_tick, last_odom;

    function new();
      target = TARGET_RST; max_rate = MAXRATE_RST; max_accel = ACCEL_RST;
      tol = TOL_RST; min_rate = MINRATE_RST; timeout = TIMEOUT_RST;
      ph = PH_WAIT; last_yaw = 0; travelled = 0; rate_now = 0;
      last_tick = 0; last_odom = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_TARGET:  target = $signed(v[22:0]);
        REG_MAXRATE: max_rate = v[19:0];
        REG_ACCEL:   max_accel = v[19:0];
        REG_TOL:     tol = v[15:0];
        REG_MINRATE: min_rate = v[19:0];
        REG_TIMEOUT: timeout = v[21:0];
        default: ;
      endcase
    endfunction

    function longint heading_of(beat_t b);
      longint x, y, z, dx, dy, t;
      longint atans[16];
      atans = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
      y = 2 * (longint'(b.qw) * b.qz + longint'(b.qx) * b.qy);
      x = (longint'(1) << 30) - 2 * (longint'(b.qy) * b.qy + longint'(b.qz) * b.qz);
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 26353589;
        end else begin
          x = -y; y = t; z = -26353589;
        end
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atans[i];
        end else begin
          x -= dx; y += dy; z -= atans[i];
        end
      end
      return (z + 128) >>> 8;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function void push(longint rate, logic [1:0] st);
      rate_cmd_t e;
      e.rate = rate[20:0];
      e.status = st;
      pending.push_back(e);
    endfunction

    function void note_beat(beat_t b);
      longint yaw, d, rem, s;
      longint unsigned kin, acc, w;
      logic [31:0] dt;
      bit pos, reached;
      if (b.cmd == CMD_ODOM) begin
        yaw = heading_of(b);
        last_odom = b.now_us;
        if (ph == PH_WAIT) begin
          last_yaw = yaw; ph = PH_INIT;
        end else begin
          d = yaw - last_yaw;
          while (d > 205887) d -= 411775;
          while (d < -205887) d += 411775;
          last_yaw = yaw;
          if (ph == PH_ROT) begin
            s = travelled + d;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            travelled = s;
          end
        end
        return;
      end
      if (ph == PH_WAIT) return;
      if (ph == PH_DONE) begin
        rate_now = 0; push(0, ST_DONE); return;
      end
      dt = b.now_us - last_tick;
      last_tick = b.now_us;
      if (dt == 0 || dt > TICK_MAX_US) return;
      if (longint'(b.now_us - last_odom) > longint'(timeout)) begin
        rate_now = 0; push(0, ST_TIMEOUT); return;
      end
      if (ph == PH_INIT) begin
        if ((target < 0 ? -target : target) < longint'(tol)) begin
          ph = PH_DONE; return;
        end
        travelled = 0; ph = PH_ROT;
      end
      pos = target >= 0;
      reached = pos ? (travelled >= target - longint'(tol))
                    : (travelled <= target + longint'(tol));
      if (reached) begin
        ph = PH_DONE; return;
      end
      rem = target - travelled;
      if (rem < 0) rem = -rem;
      kin = root_floor(2 * max_accel * longint'(rem));
      acc = rate_now + (max_accel * longint'(dt)) / 1000000;
      w = max_rate;
      if (acc < w) w = acc;
      if (kin < w) w = kin;
      if (w < min_rate) w = min_rate;
      if (w > max_rate) w = max_rate;
      rate_now = w;
      push(pos ? longint'(w) : -longint'(w), ST_DRIVE);
    endfunction

    function void check_rate(logic signed [20:0] rate, logic [1:0] st);
      rate_cmd_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rate %0d status %0d", $time, rate, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.rate !== rate) begin
        $display("%0t: angular_rate expected %0d actual %0d", $time, e.rate, rate);
        errors++;
      end
      if (e.status !== st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  rip_in_if in_ch();
  rip_out_if out_ch();

  rotate_in_place_velocity_profiler i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rate_scoreboard sb = new();
  bit quiet;
  logic [31:0] clock_us;
  longint heading;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_rate(out_ch.angular_rate, out_ch.status);

  initial begin
    int stall;
    out_ch.ready = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (quiet) out_ch.ready = 1;
      else if (stall > 0) begin
        out_ch.ready = 0; stall--;
      end else begin
        out_ch.ready = 1;
        if ($urandom_range(9) == 0) stall = $urandom_range(1, 9);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send(beat_t b);
    @(negedge clk);
    in_ch.valid = 1; in_ch.cmd = b.cmd; in_ch.now_us = b.now_us;
    in_ch.quat_x = b.qx; in_ch.quat_y = b.qy; in_ch.quat_z = b.qz; in_ch.quat_w = b.qw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_beat(b);
    if (!quiet && $urandom_range(3) == 0) begin
      @(negedge clk);
      in_ch.valid = 0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
  endtask

  task automatic odom(longint ang, logic [31:0] stamp);
    beat_t b;
    real th;
    th = real'(ang) / 131072.0;
    b.cmd = CMD_ODOM; b.now_us = stamp;
    b.qx = 0; b.qy = 0;
    b.qw = 16'($rtoi(32767.0 * $cos(th)));
    b.qz = 16'($rtoi(32767.0 * $sin(th)));
    if ($urandom_range(3) == 0) begin
      b.qx = 16'($urandom_range(0, 600) - 300);
      b.qy = 16'($urandom_range(0, 600) - 300);
    end
    send(b);
  endtask

  task automatic raw_odom(logic signed [15:0] x, y, z, w);
    beat_t b;
    b.cmd = CMD_ODOM; b.now_us = clock_us;
    b.qx = x; b.qy = y; b.qz = z; b.qw = w;
    send(b);
  endtask

  task automatic tick(logic [31:0] dt);
    beat_t b;
    clock_us += dt;
    b.cmd = CMD_TICK; b.now_us = clock_us;
    b.qx = 16'($urandom); b.qy = 16'($urandom); b.qz = 16'($urandom); b.qw = 16'($urandom);
    send(b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      heading += longint'($urandom_range(0, 8000)) - 2000;
      clock_us += $urandom_range(0, 20000);
      odom(heading, clock_us);
    end else if (r < 50) begin
      raw_odom(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (r < 53) begin
      odom(heading, $urandom_range(1) ? clock_us - 32'd3000000 : clock_us + 32'd5000);
    end else if (r < 93) begin
      tick($urandom_range(1, 150000));
    end else if (r < 96) begin
      tick(0);
    end else begin
      tick($urandom_range(1) ? 32'd1000001 : $urandom);
    end
  endtask

  initial begin
    logic [31:0] cfg[6];
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.cmd = CMD_ODOM; in_ch.now_us = 0;
    in_ch.quat_x = 0; in_ch.quat_y = 0; in_ch.quat_z = 0; in_ch.quat_w = 0;
    quiet = 0;
    heading = 0;
    clock_us = $urandom;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    tick(1000);
    tick(2000);
    raw_odom(0, 0, 0, 0);
    tick(0);
    tick(32'd2000000);
    raw_odom(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    raw_odom(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    raw_odom(-16'sh8000, 0, 0, 0);
    raw_odom(0, 16'sh7fff, 0, 0);
    odom(heading, clock_us);
    tick(20000);
    tick(20000);
    odom(heading + 3000, clock_us - 32'd1000000);
    tick(20000);
    odom(heading + 3000, clock_us + 32'd100);
    tick(20000);
    heading += 3000;
    odom(heading, clock_us);
    tick(1000000);
    tick(1000001);
    heading += 200000;
    odom(heading, clock_us);
    tick(30000);
    drain();

    for (int p = 0; p < 6; p++) begin
      cfg[REG_TARGET] = (p == 1) ? 32'h00400000 : 32'h003fffff;
      cfg[REG_MAXRATE] = (p == 2) ? 0 : (p == 3) ? 32'hfffff : $urandom_range(20000, 300000);
      cfg[REG_ACCEL] = (p == 2) ? 32'hfffff : (p == 4) ? 0 : $urandom_range(1000, 400000);
      cfg[REG_TOL] = (p == 3) ? 32'hffff : $urandom_range(0, 3000);
      cfg[REG_MINRATE] = (p == 4) ? 32'hfffff : (p == 1) ? 0 : $urandom_range(0, 40000);
      cfg[REG_TIMEOUT] = (p == 2) ? 1 : (p == 3) ? 32'h3fffff : $urandom_range(30000, 600000);
      if (p == 5) begin
        cfg[REG_TARGET] = 32'd50000;
        quiet = 1;
      end
      for (int i = 0; i < 6; i++) reg_write(i[2:0], cfg[i]);
      repeat (140) random_beat();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

[rotate_in_place_velocity_profiler.f]
+incdir+rtl/core
rtl/core/rip_pkg.sv
rtl/core/rip_in_if.sv
rtl/core/rip_out_if.sv
rtl/core/rip_cordic.sv
rtl/core/rip_isqrt.sv
rtl/core/rip_cdiv.sv
rtl/core/rotate_in_place_velocity_profiler.sv
sim/testbench.sv
